[hw/rtl/value_noise_2d_octaves_assert.svh]
// Assertion macros shared by the value noise block.
`ifndef VALUE_NOISE_2D_OCTAVES_ASSERT_SVH
`define VALUE_NOISE_2D_OCTAVES_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VN2O_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vn2o: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VN2O_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vn2o: assertion failed");

`endif

[hw/rtl/vn2o_pkg.sv]
// Package with constants, types and arithmetic helpers of the value noise block.
package vn2o_pkg;

  localparam int unsigned COS_TABLE_ENTRIES = 256;
  localparam int unsigned MAX_OCTAVES       = 8;

  localparam int unsigned W_IDX_W    = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int unsigned OCT_W      = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned MAG_W      = COORD_W + 1;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned AMP_W      = 24;
  localparam int unsigned OCTS_W     = 4;
  localparam int unsigned PERS_W     = 16;
  localparam int unsigned SEED_W     = 16;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PROD_W     = MAG_W + FREQ_W;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned ACC_W      = 34;

  // Register reset values.
  localparam logic [FREQ_W-1:0] RST_BASE_FREQ = 24'd251658;
  localparam logic [AMP_W-1:0]  RST_BASE_AMP  = 24'd65536;
  localparam logic [OCTS_W-1:0] RST_OCT_COUNT = 4'd4;
  localparam logic [PERS_W-1:0] RST_PERSIST   = 16'd16384;
  localparam logic [SEED_W-1:0] RST_SEED      = 16'd1;

  // Hash constants.
  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam int unsigned HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_FREQ = 3'd0,
    CFG_BASE_AMP  = 3'd1,
    CFG_OCT_COUNT = 3'd2,
    CFG_PERSIST   = 3'd3,
    CFG_SEED      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [FREQ_W-1:0] base_frequency;
    logic [AMP_W-1:0]  base_amplitude;
    logic [OCTS_W-1:0] octave_count;
    logic [PERS_W-1:0] persistence;
    logic [SEED_W-1:0] seed_offset;
  } cfg_t;

  // Control and side data that travel with one octave through the pipeline.
  typedef struct packed {
    logic                first;
    logic                last;
    logic                kill;
    logic [AMP_W-1:0]    amp;
    logic [WEIGHT_W-1:0] wx;
    logic [WEIGHT_W-1:0] wy;
  } oct_tag_t;

  typedef struct packed {
    logic [31:0]        ix;
    logic [31:0]        iy;
    logic [W_IDX_W-1:0] idx_x;
    logic [W_IDX_W-1:0] idx_y;
    oct_tag_t           tag;
  } oct_req_t;

  typedef struct packed {
    logic [3:0][31:0] s;
    oct_tag_t         tag;
  } smooth_t;

  typedef struct packed {
    logic [31:0] term;
    logic        first;
    logic        last;
    logic        kill;
  } term_t;

  typedef logic [COS_TABLE_ENTRIES:0][WEIGHT_W-1:0] weight_rom_t;

  // Half-period cosine weight from an eleven-term Taylor series in Q.30.
  function automatic logic [WEIGHT_W-1:0] half_weight(int unsigned i);
    logic [63:0] ang;
    logic [63:0] a2;
    logic [63:0] term;
    longint      c;
    ang  = (64'd3373259426 * 64'(i)) / 64'(COS_TABLE_ENTRIES);
    a2   = (ang * ang) >> 30;
    term = 64'd1073741824;
    c    = 64'sd1073741824;
    term = ((term * a2) >> 30) / 64'd2;   c = c - longint'(term);
    term = ((term * a2) >> 30) / 64'd12;  c = c + longint'(term);
    term = ((term * a2) >> 30) / 64'd30;  c = c - longint'(term);
    term = ((term * a2) >> 30) / 64'd56;  c = c + longint'(term);
    term = ((term * a2) >> 30) / 64'd90;  c = c - longint'(term);
    term = ((term * a2) >> 30) / 64'd132; c = c + longint'(term);
    term = ((term * a2) >> 30) / 64'd182; c = c - longint'(term);
    term = ((term * a2) >> 30) / 64'd240; c = c + longint'(term);
    term = ((term * a2) >> 30) / 64'd306; c = c - longint'(term);
    term = ((term * a2) >> 30) / 64'd380; c = c + longint'(term);
    if (c < 0) c = 0;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    return WEIGHT_W'((64'(64'sd1073741824 - c) + 64'd16384) >> 15);
  endfunction

  function automatic weight_rom_t build_weight_rom();
    weight_rom_t rom;
    for (int unsigned i = 0; i <= COS_TABLE_ENTRIES; i++) begin
      if (2 * i <= COS_TABLE_ENTRIES) begin
        rom[i] = half_weight(i);
      end else begin
        rom[i] = WEIGHT_ONE - half_weight(COS_TABLE_ENTRIES - i);
      end
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

  function automatic logic [WEIGHT_W-1:0] weight_of(logic [W_IDX_W-1:0] idx);
    return WEIGHT_ROM[idx];
  endfunction

  // Table index for a 16-bit fraction magnitude.
  function automatic logic [W_IDX_W-1:0] frac_index(logic [15:0] fr);
    logic [31:0] prod;
    prod = 32'(fr) * 32'(COS_TABLE_ENTRIES);
    return W_IDX_W'(prod >> 16);
  endfunction

  // First hash step: mix the two coordinates.
  function automatic logic [31:0] hash_start(logic [31:0] x, logic [31:0] y);
    logic [31:0] n;
    n = x + y * HASH_MUL_Y;
    return n ^ (n << HASH_SHIFT);
  endfunction

  // Last hash step and mapping to a signed Q2.30 lattice value.
  function automatic logic [31:0] lattice_value(logic [31:0] n, logic [31:0] t);
    logic [31:0] h;
    h = (n * t + HASH_C3) & HASH_MASK;
    return ONE_Q30 - h;
  endfunction

  // Floor of (a * (1 - w) + b * w) with w in Q.16.
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                        logic [WEIGHT_W-1:0] w);
    logic [WEIGHT_W-1:0] wi;
    logic signed [49:0]  s;
    wi = WEIGHT_ONE - w;
    s  = $signed(a) * $signed({1'b0, wi}) + $signed(b) * $signed({1'b0, w});
    return 32'(s >>> 16);
  endfunction

endpackage

[hw/rtl/vn2o_front.sv]
// Input stage, coordinate scaling and octave sequencer of the value noise block.
module vn2o_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vn2o_pkg::cfg_t           cfg_i,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [31:0]       x_coord_i,
  input  logic signed [31:0]       y_coord_i,
  output logic                     req_valid_o,
  output vn2o_pkg::oct_req_t       req_o
);

  // Input register: shifted coordinate magnitudes and signs.
  logic                             a_valid_q;
  logic [vn2o_pkg::MAG_W-1:0]       ax_q, ay_q;
  logic                             nx_q, ny_q;
  logic signed [vn2o_pkg::MAG_W-1:0] cx, cy, seed_ext;

  // Sequencer state.
  logic                              busy_q;
  logic [vn2o_pkg::OCT_W-1:0]        k_q;
  logic [vn2o_pkg::CNT_W-1:0]        cnt_q, cnt_clip, k_ext;
  logic [vn2o_pkg::PROD_W-1:0]       px_q, py_q, px_d, py_d, mx, my;
  logic                              nxs_q, nys_q;
  logic [vn2o_pkg::AMP_W-1:0]        amp_q;
  logic [vn2o_pkg::AMP_W+vn2o_pkg::PERS_W-1:0] amp_prod;
  logic [55:0]                       plx, ply;
  logic                              last_oct, load, accept;
  logic [31:0]                       ix_mag, iy_mag;

  logic                              req_valid_q;
  vn2o_pkg::oct_req_t                req_q, req_d;

  // Seed offset in Q16.16 added to both coordinates.
  always_comb begin
    seed_ext = vn2o_pkg::MAG_W'($signed({cfg_i.seed_offset, 16'h0000}));
    cx = vn2o_pkg::MAG_W'(x_coord_i) + seed_ext;
    cy = vn2o_pkg::MAG_W'(y_coord_i) + seed_ext;
  end

  // Octave count clipped to the supported maximum.
  always_comb begin
    if (int'(cfg_i.octave_count) > vn2o_pkg::MAX_OCTAVES) begin
      cnt_clip = vn2o_pkg::CNT_W'(vn2o_pkg::MAX_OCTAVES);
    end else begin
      cnt_clip = vn2o_pkg::CNT_W'(cfg_i.octave_count);
    end
  end

  // Handshake between the input register and the sequencer.
  always_comb begin
    k_ext      = vn2o_pkg::CNT_W'(k_q);
    last_oct   = (cnt_q == '0) || (vn2o_pkg::CNT_W'(k_ext + 1'b1) == cnt_q);
    load       = a_valid_q && adv_i && (!busy_q || last_oct);
    in_stall_o = a_valid_q && !load;
    accept     = in_valid_i && !in_stall_o;
  end

  // Magnitude times base frequency; the top magnitude bit is a shifted add.
  always_comb begin
    plx  = ax_q[31:0] * cfg_i.base_frequency;
    ply  = ay_q[31:0] * cfg_i.base_frequency;
    px_d = vn2o_pkg::PROD_W'(plx)
         + (ax_q[32] ? vn2o_pkg::PROD_W'({cfg_i.base_frequency, 32'h0}) : '0);
    py_d = vn2o_pkg::PROD_W'(ply)
         + (ay_q[32] ? vn2o_pkg::PROD_W'({cfg_i.base_frequency, 32'h0}) : '0);
    amp_prod = amp_q * cfg_i.persistence;
  end

  // Octave k scales by 2^k: pick lattice and fraction bits with a shift.
  always_comb begin
    mx     = px_q >> (vn2o_pkg::FRAC_SHIFT - int'(k_q));
    my     = py_q >> (vn2o_pkg::FRAC_SHIFT - int'(k_q));
    ix_mag = mx[47:16];
    iy_mag = my[47:16];
    req_d.ix        = nxs_q ? (32'd0 - ix_mag) : ix_mag;
    req_d.iy        = nys_q ? (32'd0 - iy_mag) : iy_mag;
    req_d.idx_x     = vn2o_pkg::frac_index(mx[15:0]);
    req_d.idx_y     = vn2o_pkg::frac_index(my[15:0]);
    req_d.tag.first = (k_q == '0);
    req_d.tag.last  = last_oct;
    req_d.tag.kill  = (cnt_q == '0);
    req_d.tag.amp   = amp_q;
    req_d.tag.wx    = '0;
    req_d.tag.wy    = '0;
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (load) begin
      a_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q <= cx[vn2o_pkg::MAG_W-1] ? vn2o_pkg::MAG_W'(-cx) : vn2o_pkg::MAG_W'(cx);
      ay_q <= cy[vn2o_pkg::MAG_W-1] ? vn2o_pkg::MAG_W'(-cy) : vn2o_pkg::MAG_W'(cy);
      nx_q <= cx[vn2o_pkg::MAG_W-1];
      ny_q <= cy[vn2o_pkg::MAG_W-1];
    end
  end

  // Sequencer control: one octave leaves per advancing cycle while busy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      cnt_q       <= '0;
      req_valid_q <= 1'b0;
    end else if (adv_i) begin
      req_valid_q <= busy_q;
      if (load) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        cnt_q  <= cnt_clip;
      end else if (busy_q && last_oct) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        k_q <= vn2o_pkg::OCT_W'(k_q + 1'b1);
      end
    end
  end

  // Sequencer payload and issued octave.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      req_q <= req_d;
      if (load) begin
        px_q  <= px_d;
        py_q  <= py_d;
        nxs_q <= nx_q;
        nys_q <= ny_q;
        amp_q <= cfg_i.base_amplitude;
      end else if (busy_q) begin
        amp_q <= amp_prod[vn2o_pkg::AMP_W+15:16];
      end
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

[hw/rtl/vn2o_lattice.sv]
// Lattice hash of sixteen points and 3x3 smoothing of the four corners.
module vn2o_lattice (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                req_valid_i,
  input  vn2o_pkg::oct_req_t  req_i,
  output logic                sm_valid_o,
  output vn2o_pkg::smooth_t   sm_o
);

  logic [4:0]         v_q;
  vn2o_pkg::oct_tag_t tag1_d;
  vn2o_pkg::oct_tag_t tag1_q, tag2_q, tag3_q, tag4_q;
  logic [31:0]        n1_q [16];
  logic [31:0]        n2_q [16];
  logic [31:0]        n3_q [16];
  logic [31:0]        sq2_q [16];
  logic [31:0]        t3_q [16];
  logic [31:0]        val4_q [16];
  vn2o_pkg::smooth_t  sm_q, sm_d;

  // Valid bits of the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], req_valid_i};
    end
  end

  // Side data of the incoming octave with its blend weights looked up.
  always_comb begin
    tag1_d    = req_i.tag;
    tag1_d.wx = vn2o_pkg::weight_of(req_i.idx_x);
    tag1_d.wy = vn2o_pkg::weight_of(req_i.idx_y);
  end

  // Smoothing: corners weigh 1, sides 2, center 4, then floor by 16.
  always_comb begin
    logic signed [35:0] acc;
    int                 gx, gy, sh;
    sm_d.tag = tag4_q;
    for (int c = 0; c < 4; c++) begin
      acc = '0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          gx  = (c % 2) + 1 + dx;
          gy  = (c / 2) + 1 + dy;
          sh  = ((dx == 0) ? 1 : 0) + ((dy == 0) ? 1 : 0);
          acc = acc + (36'($signed(val4_q[gy * 4 + gx])) <<< sh);
        end
      end
      sm_d.s[c] = 32'(acc >>> 4);
    end
  end

  // Hash pipeline: mix, square, polynomial, final product.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag1_q <= tag1_d;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      for (int p = 0; p < 16; p++) begin
        n1_q[p]   <= vn2o_pkg::hash_start(req_i.ix + 32'(p % 4) - 32'd1,
                                          req_i.iy + 32'(p / 4) - 32'd1);
        n2_q[p]   <= n1_q[p];
        sq2_q[p]  <= n1_q[p] * n1_q[p];
        n3_q[p]   <= n2_q[p];
        t3_q[p]   <= sq2_q[p] * vn2o_pkg::HASH_C1 + vn2o_pkg::HASH_C2;
        val4_q[p] <= vn2o_pkg::lattice_value(n3_q[p], t3_q[p]);
      end
      sm_q <= sm_d;
    end
  end

  assign sm_valid_o = v_q[4];
  assign sm_o       = sm_q;

endmodule

[hw/rtl/vn2o_blend.sv]
// Cosine blending along x and y and amplitude scaling of one octave.
module vn2o_blend (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               sm_valid_i,
  input  vn2o_pkg::smooth_t  sm_i,
  output logic               term_valid_o,
  output vn2o_pkg::term_t    term_o
);

  logic [2:0]         v_q;
  logic [31:0]        top_q, bot_q, mix_q;
  vn2o_pkg::oct_tag_t tag1_q, tag2_q;
  vn2o_pkg::term_t    term_q, term_d;
  logic signed [56:0] prod;

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], sm_valid_i};
    end
  end

  // Octave term: blended value times amplitude, floored to Q16.16.
  always_comb begin
    prod         = $signed(mix_q) * $signed({1'b0, tag2_q.amp});
    term_d.term  = 32'(prod >>> 30);
    term_d.first = tag2_q.first;
    term_d.last  = tag2_q.last;
    term_d.kill  = tag2_q.kill;
  end

  // Blend stages: x first on both rows, then y.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      top_q  <= vn2o_pkg::blend(sm_i.s[0], sm_i.s[1], sm_i.tag.wx);
      bot_q  <= vn2o_pkg::blend(sm_i.s[2], sm_i.s[3], sm_i.tag.wx);
      tag1_q <= sm_i.tag;
      mix_q  <= vn2o_pkg::blend(top_q, bot_q, tag1_q.wy);
      tag2_q <= tag1_q;
      term_q <= term_d;
    end
  end

  assign term_valid_o = v_q[2];
  assign term_o       = term_q;

endmodule

[hw/rtl/value_noise_2d_octaves.sv]
// Top level of the fractal 2D value noise block: registers, octave sum, output.
// Each accepted coordinate produces one saturated Q16.16 noise sample. The octave
// sequencer sends one octave per cycle while the output does not stall into a
// shared pipeline (input register, scaling multiply, issue, five hash and
// smoothing stages, three blend and amplitude stages, sum), so an item occupies
// the sequencer for one octave per configured octave, with the count clipped to
// 8 and never below one. Items follow one another without gaps. A stall on the
// output freezes the whole pipeline; configuration must be written only while
// no item is in flight, which the block itself does not enforce.
module value_noise_2d_octaves (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vn2o_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vn2o_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                x_coord_i,
  input  logic signed [31:0]                y_coord_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                noise_value_o,
  output logic                              saturated_o
);

  `include "value_noise_2d_octaves_assert.svh"

  vn2o_pkg::cfg_t     cfg_q;
  logic               adv;
  logic               req_valid, sm_valid, fin_valid;
  vn2o_pkg::oct_req_t req;
  vn2o_pkg::smooth_t  sm;
  vn2o_pkg::term_t    fin;

  logic signed [vn2o_pkg::ACC_W-1:0] acc_q, sum;
  logic                              out_valid_q, sat_q, sat_d;
  logic signed [31:0]                noise_q, noise_d;

  localparam logic signed [vn2o_pkg::ACC_W-1:0] SUM_MAX = 34'sh0_7fff_ffff;
  localparam logic signed [vn2o_pkg::ACC_W-1:0] SUM_MIN = -34'sh0_8000_0000;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_frequency <= vn2o_pkg::RST_BASE_FREQ;
      cfg_q.base_amplitude <= vn2o_pkg::RST_BASE_AMP;
      cfg_q.octave_count   <= vn2o_pkg::RST_OCT_COUNT;
      cfg_q.persistence    <= vn2o_pkg::RST_PERSIST;
      cfg_q.seed_offset    <= vn2o_pkg::RST_SEED;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vn2o_pkg::CFG_BASE_FREQ: cfg_q.base_frequency <= cfg_wdata_i;
        vn2o_pkg::CFG_BASE_AMP:  cfg_q.base_amplitude <= cfg_wdata_i;
        vn2o_pkg::CFG_OCT_COUNT: cfg_q.octave_count   <= cfg_wdata_i[vn2o_pkg::OCTS_W-1:0];
        vn2o_pkg::CFG_PERSIST:   cfg_q.persistence    <= cfg_wdata_i[vn2o_pkg::PERS_W-1:0];
        vn2o_pkg::CFG_SEED:      cfg_q.seed_offset    <= cfg_wdata_i[vn2o_pkg::SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register can take a result.
  assign adv = !out_valid_q || !out_stall_i;

  vn2o_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  vn2o_lattice u_lattice (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_valid_i (req_valid),
    .req_i       (req),
    .sm_valid_o  (sm_valid),
    .sm_o        (sm)
  );

  vn2o_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .sm_valid_i   (sm_valid),
    .sm_i         (sm),
    .term_valid_o (fin_valid),
    .term_o       (fin)
  );

  // Octave sum and saturation to the 32-bit output range.
  always_comb begin
    sum = (fin.first ? '0 : acc_q)
        + (fin.kill ? '0 : vn2o_pkg::ACC_W'($signed(fin.term)));
    sat_d = 1'b0;
    if (sum > SUM_MAX) begin
      noise_d = 32'sh7fff_ffff;
      sat_d   = 1'b1;
    end else if (sum < SUM_MIN) begin
      noise_d = 32'sh8000_0000;
      sat_d   = 1'b1;
    end else begin
      noise_d = 32'(sum);
    end
  end

  // Output register valid: set by a final octave, cleared by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && fin_valid && fin.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Running sum and result payload.
  always_ff @(posedge clk_i) begin
    if (adv && fin_valid) begin
      acc_q <= sum;
      if (fin.last) begin
        noise_q <= noise_d;
        sat_q   <= sat_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;
  assign saturated_o   = sat_q;

  // A flagged result sits at one of the two limits.
  `VN2O_ASSERT_IMPL(a_sat_at_limit, out_valid_q && sat_q, noise_q == 32'sh7fff_ffff || noise_q == 32'sh8000_0000)
  // A blocked output freezes the running sum.
  `VN2O_ASSERT_NEXT(a_stall_holds_sum, out_valid_q && out_stall_i, $stable(acc_q))
  // A taken result with no final octave behind it empties the output register.
  `VN2O_ASSERT_NEXT(a_take_clears, out_valid_q && !out_stall_i && !(fin_valid && fin.last), !out_valid_q)

endmodule
